// ===== sv/csdsb_pkg.sv =====
// ----------------------------------------------------------------------------
// csdsb_pkg
// Shared types, constants and neighbour tables for the stage scoreboard.
// ----------------------------------------------------------------------------
package csdsb_pkg;

  localparam int DEF_MAX_COLS      = 128;
  localparam int DEF_MAX_ROWS      = 128;
  localparam int DEF_MAX_REF_WAITS = 32;
  localparam int CW                = 11;   // signed coordinate width
  localparam int NB_TOTAL          = 22;

  // Input functions.
  localparam logic [1:0] FN_FRAME = 2'd0;
  localparam logic [1:0] FN_PARSE = 2'd1;
  localparam logic [1:0] FN_REF   = 2'd2;
  localparam logic [1:0] FN_DONE  = 2'd3;

  // Stage codes.
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_INTER = 3'd1;
  localparam logic [2:0] ST_RECON = 3'd2;
  localparam logic [2:0] ST_LMCS  = 3'd3;
  localparam logic [2:0] ST_DBV   = 3'd4;
  localparam logic [2:0] ST_DBH   = 3'd5;
  localparam logic [2:0] ST_SAO   = 3'd6;
  localparam logic [2:0] ST_ALF   = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_COLS = 1'b0;
  localparam logic CFG_ROWS = 1'b1;

  // Credit levels (target plus one) of the fixed stages.
  localparam logic [6:0] LIM_RECON = 7'd3;
  localparam logic [6:0] LIM_LMCS  = 7'd4;
  localparam logic [6:0] LIM_DBV   = 7'd3;
  localparam logic [6:0] LIM_DBH   = 7'd3;
  localparam logic [6:0] LIM_SAO   = 7'd6;
  localparam logic [6:0] LIM_ALF   = 7'd9;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_WRITE, S_FLUSH
  } state_t;

  typedef struct packed {
    logic [6:0] refs;
    logic [3:0] c7;
    logic [2:0] c6;
    logic [1:0] c5;
    logic [1:0] c4;
    logic [2:0] c3;
    logic [1:0] c2;
    logic [6:0] c1;
  } rec_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
    logic [2:0]        st;
  } nb_t;

  function automatic nb_t mk(logic signed [1:0] dx, logic signed [1:0] dy,
                             logic [2:0] st);
    nb_t e;
    e.dx = dx;
    e.dy = dy;
    e.st = st;
    return e;
  endfunction

  // All neighbour credits, grouped by finished stage.
  function automatic nb_t nb_flat(logic [4:0] i);
    nb_t e;
    case (i)
      5'd0:    e = mk(-2'sd1,  2'sd1, ST_RECON);
      5'd1:    e = mk( 2'sd1,  2'sd0, ST_RECON);
      5'd2:    e = mk(-2'sd1, -2'sd1, ST_LMCS);
      5'd3:    e = mk( 2'sd0, -2'sd1, ST_LMCS);
      5'd4:    e = mk(-2'sd1,  2'sd0, ST_LMCS);
      5'd5:    e = mk(-2'sd1,  2'sd0, ST_DBV);
      5'd6:    e = mk( 2'sd1,  2'sd0, ST_DBV);
      5'd7:    e = mk(-2'sd1,  2'sd0, ST_DBH);
      5'd8:    e = mk( 2'sd0,  2'sd1, ST_DBH);
      5'd9:    e = mk(-2'sd1, -2'sd1, ST_SAO);
      5'd10:   e = mk( 2'sd0, -2'sd1, ST_SAO);
      5'd11:   e = mk(-2'sd1,  2'sd0, ST_SAO);
      5'd12:   e = mk( 2'sd1, -2'sd1, ST_SAO);
      5'd13:   e = mk( 2'sd1,  2'sd0, ST_SAO);
      5'd14:   e = mk(-2'sd1, -2'sd1, ST_ALF);
      5'd15:   e = mk( 2'sd0, -2'sd1, ST_ALF);
      5'd16:   e = mk(-2'sd1,  2'sd0, ST_ALF);
      5'd17:   e = mk( 2'sd1, -2'sd1, ST_ALF);
      5'd18:   e = mk(-2'sd1,  2'sd1, ST_ALF);
      5'd19:   e = mk( 2'sd1,  2'sd0, ST_ALF);
      5'd20:   e = mk( 2'sd0,  2'sd1, ST_ALF);
      5'd21:   e = mk( 2'sd1,  2'sd1, ST_ALF);
      default: e = mk( 2'sd0,  2'sd0, ST_NONE);
    endcase
    return e;
  endfunction

  function automatic logic [4:0] list_start(logic [2:0] st);
    logic [4:0] r;
    case (st)
      ST_LMCS: r = 5'd5;
      ST_DBV:  r = 5'd6;
      ST_DBH:  r = 5'd8;
      ST_SAO:  r = 5'd14;
      ST_ALF:  r = 5'd22;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] list_len(logic [2:0] st);
    logic [3:0] r;
    case (st)
      ST_RECON: r = 4'd5;
      ST_LMCS:  r = 4'd1;
      ST_DBV:   r = 4'd2;
      ST_DBH:   r = 4'd6;
      ST_SAO:   r = 4'd8;
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

  // Credits a unit at the given picture edges receives from outside the frame.
  function automatic logic [3:0] precount(logic [2:0] s, logic l, logic r,
                                          logic t, logic b);
    logic [3:0] n;
    nb_t        e;
    n = 4'd0;
    for (int i = 0; i < NB_TOTAL; i++) begin
      e = nb_flat(5'(i));
      if (e.st == s && ((e.dx == 2'sd1 && l) || (e.dx == -2'sd1 && r) ||
                        (e.dy == 2'sd1 && t) || (e.dy == -2'sd1 && b))) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/csdsb_store.sv =====
// ----------------------------------------------------------------------------
// csdsb_store
// Unit record memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module csdsb_store #(
  parameter int AW = 14
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  csdsb_pkg::rec_t wdata,
  input  logic [AW-1:0]   raddr,
  output csdsb_pkg::rec_t rdata
);
  import csdsb_pkg::*;

  rec_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/csdsb_credit_unit.sv =====
// ----------------------------------------------------------------------------
// csdsb_credit_unit
// Adds one saturating credit to one stage counter of a unit record.
// ----------------------------------------------------------------------------
module csdsb_credit_unit (
  input  csdsb_pkg::rec_t rd,
  input  logic [2:0]      stage,
  input  logic            set_refs,
  input  logic [6:0]      new_refs,
  output csdsb_pkg::rec_t wr,
  output logic            emit
);
  import csdsb_pkg::*;

  rec_t       base;
  logic [6:0] cnt;
  logic [6:0] lim;
  logic [6:0] cnt_n;

  always_comb begin
    base = rd;
    if (set_refs) begin
      base.refs = new_refs;
    end
    case (stage)
      ST_INTER: begin cnt = base.c1;       lim = base.refs + 7'd1; end
      ST_RECON: begin cnt = 7'(base.c2);   lim = LIM_RECON; end
      ST_LMCS:  begin cnt = 7'(base.c3);   lim = LIM_LMCS;  end
      ST_DBV:   begin cnt = 7'(base.c4);   lim = LIM_DBV;   end
      ST_DBH:   begin cnt = 7'(base.c5);   lim = LIM_DBH;   end
      ST_SAO:   begin cnt = 7'(base.c6);   lim = LIM_SAO;   end
      ST_ALF:   begin cnt = 7'(base.c7);   lim = LIM_ALF;   end
      default:  begin cnt = 7'd0;          lim = 7'd0;      end
    endcase
    // A saturated counter keeps its value and reports nothing.
    cnt_n = (cnt < lim) ? cnt + 7'd1 : cnt;
    emit  = (cnt < lim) && (cnt_n == lim);
    wr    = base;
    case (stage)
      ST_INTER: wr.c1 = cnt_n;
      ST_RECON: wr.c2 = cnt_n[1:0];
      ST_LMCS:  wr.c3 = cnt_n[2:0];
      ST_DBV:   wr.c4 = cnt_n[1:0];
      ST_DBH:   wr.c5 = cnt_n[1:0];
      ST_SAO:   wr.c6 = cnt_n[2:0];
      ST_ALF:   wr.c7 = cnt_n[3:0];
      default:  wr = base;
    endcase
  end

endmodule

// ===== sv/ctu_stage_dependency_scoreboard_unit.sv =====
// ----------------------------------------------------------------------------
// ctu_stage_dependency_scoreboard_unit
// Per coding tree unit stage scoreboard with a shared credit unit.
// ----------------------------------------------------------------------------
// The block takes one word when start is high and busy is low, and reports
// every stage that became ready as one result word on out_valid for a single
// cycle; the receiver cannot stall, so results must be taken as they come.
// Parse done, reference ready and stage done words are each worked through
// one credit target at a time, by read-modify-write of the single record
// memory through the shared credit unit; a credit that lands outside the
// frame is dropped without a write. A frame start sweeps the
// whole record memory, one entry a cycle, writing each unit's out-of-frame
// pre-credits to all 2**(XW+YW) entries, 16384 at the default size. The same
// sweep runs after reset, writing zeros, and busy stays high until it ends.
// Configuration words are taken only while the block is idle and no word is
// being started in the same cycle.
module ctu_stage_dependency_scoreboard_unit #(
  parameter int MAX_COLS      = csdsb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS      = csdsb_pkg::DEF_MAX_ROWS,
  parameter int MAX_REF_WAITS = csdsb_pkg::DEF_MAX_REF_WAITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [6:0] in_ctu_x,
  input  logic [6:0] in_ctu_y,
  input  logic [2:0] in_done_stage,
  input  logic [5:0] in_ref_count,
  output logic       out_valid,
  output logic [6:0] out_ready_x,
  output logic [6:0] out_ready_y,
  output logic [2:0] out_ready_stage,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import csdsb_pkg::*;

  localparam int XW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW = XW + YW;

  state_t      st_r, st_nxt;
  logic [7:0]  cols_r, cols_nxt, rows_r, rows_nxt;
  logic [9:0]  w0_r, w0_nxt, h0_r, h0_nxt;      // frame size at last frame start
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [6:0]  x_r, x_nxt, y_r, y_nxt;
  logic [2:0]  stg_r, stg_nxt;
  logic [6:0]  refs_r, refs_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [6:0]  pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic [2:0]  pend_s_r, pend_s_nxt;
  logic        ov_r, ov_nxt, ol_r, ol_nxt;
  logic [6:0]  ox_r, ox_nxt, oy_r, oy_nxt;
  logic [2:0]  os_r, os_nxt;

  logic [9:0]  eff_cols, eff_rows;
  logic [9:0]  cmax, rmax;
  logic [3:0]  nsteps;
  nb_t         ent;
  logic signed [CW-1:0] tx, ty;
  logic [2:0]  ts;
  logic        t_in;
  logic [AW-1:0] taddr;
  logic [9:0]  su, sv;
  rec_t        fresh, rd, wr;
  logic        emit;
  logic        we;
  logic [AW-1:0] waddr;
  rec_t        wdata;
  logic        in_ok;
  logic [6:0]  sat_refs;

  assign cmax = 10'(MAX_COLS);
  assign rmax = 10'(MAX_ROWS);

  // Zero acts as one, and sizes above the memory clip to it.
  always_comb begin
    eff_cols = (cols_r == 8'd0) ? 10'd1 : 10'(cols_r);
    if (eff_cols > cmax) eff_cols = cmax;
    eff_rows = (rows_r == 8'd0) ? 10'd1 : 10'(rows_r);
    if (eff_rows > rmax) eff_rows = rmax;
  end

  assign sat_refs = ({1'b0, in_ref_count} > 7'(MAX_REF_WAITS)) ?
                    7'(MAX_REF_WAITS) : {1'b0, in_ref_count};

  assign in_ok = (10'(in_ctu_x) < eff_cols) && (10'(in_ctu_y) < eff_rows);

  // Credit target of the current step: for a stage done, the neighbour list first,
  // then the next stage of the unit itself; for other words, its inter counter.
  always_comb begin
    ent = nb_flat(list_start(stg_r) + 5'(idx_r));
    if (func_r != FN_DONE) begin
      nsteps = 4'd1;
      tx = CW'(x_r);
      ty = CW'(y_r);
      ts = ST_INTER;
    end else begin
      nsteps = list_len(stg_r) + ((stg_r != ST_ALF) ? 4'd1 : 4'd0);
      if (idx_r < list_len(stg_r)) begin
        tx = CW'(x_r) + CW'(ent.dx);
        ty = CW'(y_r) + CW'(ent.dy);
        ts = ent.st;
      end else begin
        tx = CW'(x_r);
        ty = CW'(y_r);
        ts = stg_r + 3'd1;
      end
    end
    t_in  = (tx >= 0) && (ty >= 0) && (tx < $signed({1'b0, eff_cols})) &&
            (ty < $signed({1'b0, eff_rows}));
    taddr = {ty[YW-1:0], tx[XW-1:0]};
  end

  // Record written by the sweep: pre-credits for units of the frame that the
  // last frame start saw, zero elsewhere and after reset.
  always_comb begin
    su    = 10'(sweep_r[XW-1:0]);
    sv    = 10'(sweep_r[AW-1:XW]);
    fresh = '0;
    if (su < w0_r && sv < h0_r) begin
      fresh.c2 = 2'(precount(ST_RECON, su == 10'd0, su == w0_r - 10'd1,
                             sv == 10'd0, sv == h0_r - 10'd1));
      fresh.c3 = 3'(precount(ST_LMCS, su == 10'd0, su == w0_r - 10'd1,
                             sv == 10'd0, sv == h0_r - 10'd1));
      fresh.c4 = 2'(precount(ST_DBV, su == 10'd0, su == w0_r - 10'd1,
                             sv == 10'd0, sv == h0_r - 10'd1));
      fresh.c5 = 2'(precount(ST_DBH, su == 10'd0, su == w0_r - 10'd1,
                             sv == 10'd0, sv == h0_r - 10'd1));
      fresh.c6 = 3'(precount(ST_SAO, su == 10'd0, su == w0_r - 10'd1,
                             sv == 10'd0, sv == h0_r - 10'd1));
      fresh.c7 = precount(ST_ALF, su == 10'd0, su == w0_r - 10'd1,
                          sv == 10'd0, sv == h0_r - 10'd1);
    end
  end

  csdsb_store #(.AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (taddr),
    .rdata (rd)
  );

  csdsb_credit_unit u_credit (
    .rd       (rd),
    .stage    (ts),
    .set_refs (func_r == FN_PARSE),
    .new_refs (refs_r),
    .wr       (wr),
    .emit     (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_INIT;
      sweep_r  <= '0;
      w0_r     <= 10'd0;
      h0_r     <= 10'd0;
      cols_r   <= 8'd1;
      rows_r   <= 8'd1;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
      idx_r    <= 4'd0;
    end else begin
      st_r     <= st_nxt;
      sweep_r  <= sweep_nxt;
      w0_r     <= w0_nxt;
      h0_r     <= h0_nxt;
      cols_r   <= cols_nxt;
      rows_r   <= rows_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    stg_r    <= stg_nxt;
    refs_r   <= refs_nxt;
    pend_x_r <= pend_x_nxt;
    pend_y_r <= pend_y_nxt;
    pend_s_r <= pend_s_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    os_r     <= os_nxt;
    ol_r     <= ol_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    sweep_nxt  = sweep_r;
    w0_nxt     = w0_r;
    h0_nxt     = h0_r;
    cols_nxt   = cols_r;
    rows_nxt   = rows_r;
    func_nxt   = func_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    stg_nxt    = stg_r;
    refs_nxt   = refs_r;
    idx_nxt    = idx_r;
    pend_v_nxt = pend_v_r;
    pend_x_nxt = pend_x_r;
    pend_y_nxt = pend_y_r;
    pend_s_nxt = pend_s_r;
    ov_nxt     = 1'b0;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    os_nxt     = os_r;
    ol_nxt     = ol_r;
    we         = 1'b0;
    waddr      = taddr;
    wdata      = wr;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_COLS) cols_nxt = cfg_data;
      else                       rows_nxt = cfg_data;
    end

    case (st_r)
      S_INIT: begin
        we        = 1'b1;
        waddr     = sweep_r;
        wdata     = fresh;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          x_nxt    = in_ctu_x;
          y_nxt    = in_ctu_y;
          stg_nxt  = in_done_stage;
          refs_nxt = sat_refs;
          idx_nxt  = 4'd0;
          if (in_func == FN_FRAME) begin
            w0_nxt    = eff_cols;
            h0_nxt    = eff_rows;
            sweep_nxt = '0;
            st_nxt    = S_INIT;
          end else if (in_ok && !(in_func == FN_DONE && in_done_stage == ST_NONE)) begin
            st_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        // The read address is the current target; its data arrive next cycle.
        if (idx_r >= nsteps) begin
          st_nxt = S_FLUSH;
        end else if (!t_in) begin
          idx_nxt = idx_r + 4'd1;
        end else begin
          st_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        we      = 1'b1;
        idx_nxt = idx_r + 4'd1;
        st_nxt  = S_READ;
        if (emit) begin
          // A newer result proves the held one is not the last.
          if (pend_v_r) begin
            ov_nxt = 1'b1;
            ox_nxt = pend_x_r;
            oy_nxt = pend_y_r;
            os_nxt = pend_s_r;
            ol_nxt = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pend_x_nxt = tx[6:0];
          pend_y_nxt = ty[6:0];
          pend_s_nxt = ts;
        end
      end
      S_FLUSH: begin
        if (pend_v_r) begin
          ov_nxt = 1'b1;
          ox_nxt = pend_x_r;
          oy_nxt = pend_y_r;
          os_nxt = pend_s_r;
          ol_nxt = 1'b1;
        end
        pend_v_nxt = 1'b0;
        st_nxt     = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign busy            = (st_r != S_IDLE);
  assign cfg_ready       = (st_r == S_IDLE) && !start;
  assign out_valid       = ov_r;
  assign out_ready_x     = ox_r;
  assign out_ready_y     = oy_r;
  assign out_ready_stage = os_r;
  assign out_last        = ol_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stage scoreboard: a queue-fed driver, a
// monitor with a behavioral scoreboard model, and a no-progress watchdog.
// ----------------------------------------------------------------------------
module tb;
  import csdsb_pkg::*;

  // Work queue entry kinds. A pause waits until the block is quiet, a mode
  // entry changes how often the sender idles.
  localparam logic [1:0] OP_WORD  = 2'd0;
  localparam logic [1:0] OP_CFG   = 2'd1;
  localparam logic [1:0] OP_PAUSE = 2'd2;
  localparam logic [1:0] OP_MODE  = 2'd3;

  localparam int GRID        = 128;
  localparam int QUIET_WAIT  = 40;     // well beyond the longest stage done
  localparam int STALL_LIMIT = 60000;  // covers a full record sweep

  typedef struct {
    logic [1:0] kind;
    logic [1:0] func;
    logic [6:0] x;
    logic [6:0] y;
    logic [2:0] stage;
    logic [5:0] refs;
    logic       cfg_idx;
    logic [7:0] cfg_val;
    int         idle_pct;
  } op_t;

  typedef struct {
    logic [6:0] x;
    logic [6:0] y;
    logic [2:0] stage;
    logic       last;
  } ready_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_func = '0;
  logic [6:0] in_ctu_x = '0;
  logic [6:0] in_ctu_y = '0;
  logic [2:0] in_done_stage = '0;
  logic [5:0] in_ref_count = '0;
  logic       out_valid;
  logic [6:0] out_ready_x;
  logic [6:0] out_ready_y;
  logic [2:0] out_ready_stage;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  always #6 clk = ~clk;

  ctu_stage_dependency_scoreboard_unit i_dut (
    .clk, .rst_n, .start, .busy,
    .in_func, .in_ctu_x, .in_ctu_y, .in_done_stage, .in_ref_count,
    .out_valid, .out_ready_x, .out_ready_y, .out_ready_stage, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // --------------------------------------------------------------------------
  // Scoreboard model. Each unit keeps seven credit counters and the inter
  // target; a counter that reaches its ready level produces one ready word.
  // --------------------------------------------------------------------------
  int unsigned credits [0:GRID*GRID-1][1:7];
  int unsigned inter_target [0:GRID*GRID-1];
  int unsigned cols_reg = 1;
  int unsigned rows_reg = 1;
  ready_t      ready_exp[$];
  ready_t      fresh[$];

  // Neighbour credits grouped by the finished stage that sends them.
  int          nb_dx [0:21] = '{-1, 1, -1, 0, -1, -1, 1, -1, 0, -1, 0, -1, 1, 1,
                                -1, 0, -1, 1, -1, 1, 0, 1};
  int          nb_dy [0:21] = '{1, 0, -1, -1, 0, 0, 0, 0, 1, -1, -1, 0, -1, 0,
                                -1, -1, 0, -1, 1, 0, 1, 1};
  logic [2:0]  nb_st [0:21] = '{ST_RECON, ST_RECON, ST_LMCS, ST_LMCS, ST_LMCS,
                                ST_DBV, ST_DBV, ST_DBH, ST_DBH, ST_SAO, ST_SAO,
                                ST_SAO, ST_SAO, ST_SAO, ST_ALF, ST_ALF, ST_ALF,
                                ST_ALF, ST_ALF, ST_ALF, ST_ALF, ST_ALF};
  int          nb_first [0:7] = '{0, 0, 0, 5, 6, 8, 14, 22};
  int          nb_count [0:7] = '{0, 0, 5, 1, 2, 6, 8, 0};

  function automatic int frame_cols();
    int c;
    c = (cols_reg == 0) ? 1 : int'(cols_reg);
    return (c > GRID) ? GRID : c;
  endfunction

  function automatic int frame_rows();
    int r;
    r = (rows_reg == 0) ? 1 : int'(rows_reg);
    return (r > GRID) ? GRID : r;
  endfunction

  function automatic int unsigned ready_level(int idx, logic [2:0] st);
    case (st)
      ST_INTER: return inter_target[idx] + 1;
      ST_RECON: return LIM_RECON;
      ST_LMCS:  return LIM_LMCS;
      ST_DBV:   return LIM_DBV;
      ST_DBH:   return LIM_DBH;
      ST_SAO:   return LIM_SAO;
      default:  return LIM_ALF;
    endcase
  endfunction

  // One credit to one counter; off-picture credits vanish and a full
  // counter stays where it is.
  function automatic void add_credit(int x, int y, logic [2:0] st, bit report);
    int          idx;
    int unsigned lvl;
    ready_t      r;
    if (x < 0 || y < 0 || x >= frame_cols() || y >= frame_rows() ||
        st == ST_NONE) return;
    idx = y * GRID + x;
    lvl = ready_level(idx, st);
    if (credits[idx][st] >= lvl) return;
    credits[idx][st]++;
    if (report && credits[idx][st] == lvl) begin
      r.x = 7'(x);
      r.y = 7'(y);
      r.stage = st;
      r.last = 1'b0;
      fresh.push_back(r);
    end
  endfunction

  // A finished stage credits its neighbour list, then the unit's next stage.
  function automatic void stage_finished(int x, int y, logic [2:0] st, bit report);
    for (int i = 0; i < nb_count[st]; i++)
      add_credit(x + nb_dx[nb_first[st] + i], y + nb_dy[nb_first[st] + i],
                 nb_st[nb_first[st] + i], report);
    if (st >= ST_INTER && st < ST_ALF) add_credit(x, y, st + 3'd1, report);
  endfunction

  // Frame start: wipe every record, then hand out the credits that the ring
  // of units just outside the picture would have given.
  function automatic void start_frame();
    int w;
    int h;
    w = frame_cols();
    h = frame_rows();
    for (int i = 0; i < GRID * GRID; i++) begin
      inter_target[i] = 0;
      for (int s = 1; s <= 7; s++) credits[i][s] = 0;
    end
    for (int s = ST_RECON; s <= ST_ALF; s++) begin
      for (int x = -1; x <= w; x++) begin
        stage_finished(x, -1, 3'(s), 1'b0);
        stage_finished(x, h, 3'(s), 1'b0);
      end
      for (int y = 0; y < h; y++) begin
        stage_finished(-1, y, 3'(s), 1'b0);
        stage_finished(w, y, 3'(s), 1'b0);
      end
    end
  endfunction

  // Work out the ready words that one accepted word causes.
  function automatic void predict_word(logic [1:0] func, logic [6:0] x,
                                       logic [6:0] y, logic [2:0] st,
                                       logic [5:0] refs);
    int unsigned t;
    fresh.delete();
    if (func == FN_FRAME) begin
      start_frame();
      return;
    end
    if (int'(x) >= frame_cols() || int'(y) >= frame_rows()) return;
    case (func)
      FN_PARSE: begin
        t = (refs > DEF_MAX_REF_WAITS) ? DEF_MAX_REF_WAITS : refs;
        inter_target[int'(y) * GRID + int'(x)] = t;
        add_credit(x, y, ST_INTER, 1'b1);
      end
      FN_REF: add_credit(x, y, ST_INTER, 1'b1);
      default: begin
        if (st != ST_NONE) stage_finished(x, y, st, 1'b1);
      end
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) ready_exp.push_back(fresh[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: compare each ready word with the oldest expectation, then feed
  // newly accepted words and register writes into the model.
  // --------------------------------------------------------------------------
  int     mismatches = 0;
  int     stall_cycles = 0;
  ready_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (ready_exp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected ready word: x=%0d y=%0d stage=%0d last=%0d",
                     out_ready_x, out_ready_y, out_ready_stage, out_last);
        end else begin
          want = ready_exp.pop_front();
          if (out_ready_x !== want.x || out_ready_y !== want.y ||
              out_ready_stage !== want.stage || out_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ready word mismatch: expected x=%0d y=%0d stage=%0d last=%0d,%s",
                       want.x, want.y, want.stage, want.last,
                       $sformatf(" got x=%0d y=%0d stage=%0d last=%0d",
                                 out_ready_x, out_ready_y, out_ready_stage,
                                 out_last));
          end
        end
      end
      if (start && !busy)
        predict_word(in_func, in_ctu_x, in_ctu_y, in_done_stage, in_ref_count);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COLS) cols_reg = cfg_data;
        else rows_reg = cfg_data;
      end
      // The watchdog resets on any transfer on any channel.
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: works through the queue at the falling edge. A word or register
  // write that was not taken at the last rising edge is simply held.
  // --------------------------------------------------------------------------
  op_t work[$];
  op_t head;
  logic word_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   idle_pct = 0;
  int   quiet_cnt = 0;

  always @(posedge clk) begin
    word_taken <= start && !busy;
    cfg_taken  <= cfg_valid && cfg_ready;
  end

  always @(negedge clk) begin
    logic nxt_start;
    logic nxt_cfg;
    nxt_start = start && !word_taken;
    nxt_cfg = cfg_valid && !cfg_taken;
    if (rst_n && !nxt_start && !nxt_cfg && work.size() > 0) begin
      head = work[0];
      case (head.kind)
        OP_MODE: begin
          idle_pct = head.idle_pct;
          void'(work.pop_front());
        end
        OP_PAUSE: begin
          // Hold off until every ready word has arrived and the block is idle.
          if (ready_exp.size() == 0 && !busy) begin
            quiet_cnt++;
            if (quiet_cnt >= QUIET_WAIT) begin
              quiet_cnt = 0;
              void'(work.pop_front());
            end
          end else begin
            quiet_cnt = 0;
          end
        end
        OP_CFG: begin
          nxt_cfg = 1'b1;
          cfg_index <= head.cfg_idx;
          cfg_data <= head.cfg_val;
          void'(work.pop_front());
        end
        default: begin
          if ($urandom_range(99) >= idle_pct) begin
            nxt_start = 1'b1;
            in_func <= head.func;
            in_ctu_x <= head.x;
            in_ctu_y <= head.y;
            in_done_stage <= head.stage;
            in_ref_count <= head.refs;
            void'(work.pop_front());
          end
        end
      endcase
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void add_word(logic [1:0] func, int x, int y, int st, int refs);
    op_t o;
    o = '{default: '0};
    o.kind = OP_WORD;
    o.func = func;
    o.x = 7'(x);
    o.y = 7'(y);
    o.stage = 3'(st);
    o.refs = 6'(refs);
    work.push_back(o);
  endfunction

  function automatic void add_cfg(logic idx, int val);
    op_t o;
    o = '{default: '0};
    o.kind = OP_CFG;
    o.cfg_idx = idx;
    o.cfg_val = 8'(val);
    work.push_back(o);
  endfunction

  function automatic void add_pause();
    op_t o;
    o = '{default: '0};
    o.kind = OP_PAUSE;
    work.push_back(o);
  endfunction

  function automatic void add_mode(int pct);
    op_t o;
    o = '{default: '0};
    o.kind = OP_MODE;
    o.idle_pct = pct;
    work.push_back(o);
  endfunction

  // Random word that is never a frame start, used as noise inside a frame.
  function automatic void add_noise();
    add_word(2'($urandom_range(3, 1)), $urandom_range(127), $urandom_range(127),
             $urandom_range(7), $urandom_range(63));
  endfunction

  // A well-formed small frame: parse and reference waits for every unit,
  // then each stage finishes across the picture, with a little noise mixed in.
  function automatic void add_frame(int w, int h);
    int refs;
    add_pause();
    add_cfg(CFG_COLS, w);
    add_cfg(CFG_ROWS, h);
    add_word(FN_FRAME, 0, 0, 0, 0);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        refs = $urandom_range(2);
        add_word(FN_PARSE, x, y, 0, refs);
        for (int r = 0; r < refs; r++) add_word(FN_REF, x, y, 0, 0);
      end
    for (int s = ST_INTER; s <= ST_ALF; s++)
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++) begin
          add_word(FN_DONE, x, y, s, 0);
          if ($urandom_range(9) == 0) add_noise();
        end
  endfunction

  initial begin
    int pct [0:3];
    pct = '{0, 77, 18, 0};

    // Directed: largest picture, far corner, every field at its extremes.
    add_pause();
    add_cfg(CFG_COLS, 255);
    add_cfg(CFG_ROWS, 255);
    add_word(FN_FRAME, 127, 127, 7, 63);
    add_word(FN_PARSE, 127, 127, 0, 63);
    add_word(FN_REF, 127, 127, 0, 0);
    add_word(FN_DONE, 127, 127, ST_ALF, 0);
    add_word(FN_DONE, 0, 0, ST_RECON, 0);
    add_word(FN_DONE, 5, 5, ST_NONE, 0);
    add_word(FN_DONE, 126, 0, ST_SAO, 0);
    // Single-unit picture from zero registers: every stage follows at once.
    add_pause();
    add_cfg(CFG_COLS, 0);
    add_cfg(CFG_ROWS, 0);
    add_word(FN_FRAME, 0, 0, 0, 0);
    add_word(FN_REF, 0, 0, 0, 0);        // before parse: inter ready early
    add_word(FN_PARSE, 0, 0, 0, 2);      // target replaced, not added to
    add_word(FN_PARSE, 0, 0, 0, 2);
    for (int s = ST_INTER; s <= ST_ALF; s++) add_word(FN_DONE, 0, 0, s, 0);
    add_word(FN_DONE, 0, 0, ST_RECON, 0); // counters already full
    add_word(FN_DONE, 1, 0, ST_RECON, 0); // unit outside the picture
    add_word(FN_PARSE, 0, 1, 0, 1);
    // Bounds change without a new frame start take effect at once.
    add_pause();
    add_cfg(CFG_COLS, 2);
    add_word(FN_DONE, 1, 0, ST_RECON, 0);
    add_word(FN_DONE, 0, 0, ST_LMCS, 0);

    // Random part, phase by phase with the sender idling set per phase.
    for (int p = 0; p < 4; p++) begin
      add_mode(pct[p]);
      add_frame($urandom_range(2, 1), $urandom_range(2, 1));
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (work.size() > 0 || start || cfg_valid) @(posedge clk);
    while (ready_exp.size() > 0) @(posedge clk);
    repeat (QUIET_WAIT) @(posedge clk);
    if (mismatches == 0 && ready_exp.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
